// File: hw/rtl/b64d_pkg.sv
// Shared types, constants and the character decode function of the base64 decoder.
package b64d_pkg;

   localparam logic [7:0] PLUS_CODE  = 8'h2B;
   localparam logic [7:0] SLASH_CODE = 8'h2F;
   localparam logic [7:0] PAD_CODE   = 8'h3D;
   localparam logic [2:0] PAD_MAX    = 3'd7;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One decoded group handed from the front to the back.
   typedef struct packed {
      logic [23:0] word;     // three bytes, first byte in the top bits
      logic [1:0]  nbytes;   // bytes to emit; zero means end marker only
      logic        final_grp;
      logic        bad;
   } job_type;

   // Queue status seen by both neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [5:0] s;
      s = 6'd0;
      if (c inside {[8'h41:8'h5A]}) begin
         s = 6'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         s = 6'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         s = 6'(c - 8'h30 + 8'd52);
      end else if (c == PLUS_CODE) begin
         s = 6'd62;
      end else if (c == SLASH_CODE) begin
         s = 6'd63;
      end
      return s;
   endfunction

endpackage

// File: hw/rtl/b64d_ifs.sv
// Valid/ready channel interfaces for the request and response streams.
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       final_char;

   modport source (output valid, output char_code, output final_char, input ready);
   modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_output;
   logic       no_byte;
   logic       bad_length;

   modport source (output valid, output data_byte, output end_of_output,
                   output no_byte, output bad_length, input ready);
   modport sink   (input valid, input data_byte, input end_of_output,
                   input no_byte, input bad_length, output ready);
endinterface

// File: hw/rtl/base64_stream_decoder_unit.sv
// Top level of the streaming base64 decoder: front, job queue and back.
//
//  channel | interface    | beat
//  --------+--------------+-----------------------------------------------
//  req     | b64d_req_if  | one character code with its final flag
//  rsp     | b64d_rsp_if  | one decoded byte, or an end marker, with flags
//
// One character is taken per cycle while the job queue is not full; a group of four
// yields three response beats, so the back drains a full group while the front
// already takes the next characters. A finished group travels through a
// four-entry job queue; the front stalls only when that queue is full.
// A job enters the back no earlier than the cycle after it is queued. Reset
// is synchronous and clears the group state, the queue pointers and the back's busy flag.
module base64_stream_decoder_unit (
   input logic        clock,
   input logic        reset,
   b64d_req_if.sink   req,
   b64d_rsp_if.source rsp
);
   import b64d_pkg::*;

   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type q_status;

   // Classify each character and hand complete or final groups to the queue.
   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .char_code  (req.char_code),
      .final_char (req.final_char),
      .q_status   (q_status),
      .push       (push),
      .job        (push_job)
   );

   // Hold groups between the two sides so each can stall on its own.
   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // Advance through the bytes of the held group, one beat per cycle while rsp is ready.
   b64d_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .head_job      (head_job),
      .pop           (pop),
      .out_valid     (rsp.valid),
      .out_ready     (rsp.ready),
      .data_byte     (rsp.data_byte),
      .end_of_output (rsp.end_of_output),
      .no_byte       (rsp.no_byte),
      .bad_length    (rsp.bad_length)
   );

`ifndef SYNTHESIS
   a_marker_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.no_byte) |-> rsp.end_of_output)
      else $error("end-marker-only beat without end flag");

   a_bad_on_marker : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.bad_length) |-> rsp.no_byte)
      else $error("bad_length on a beat that carries a byte");

   a_queue_sane : assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("job pushed into a full queue");
`endif

endmodule

// File: hw/rtl/b64d_front.sv
// Front end: accepts characters, packs sextets and builds one job per group.
module b64d_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [7:0]                char_code,
   input  logic                      final_char,
   input  b64d_pkg::queue_status_type q_status,
   output logic                      push,
   output b64d_pkg::job_type         job
);
   import b64d_pkg::*;

   logic [17:0] buf_ff, buf_in;
   logic [1:0]  pos_ff, pos_in;
   logic [2:0]  pads_ff, pads_in;

   logic        accept;
   logic [5:0]  s;
   logic [23:0] full_w;
   logic [23:0] shifted;
   logic [2:0]  n;
   logic [2:0]  pads_eff;
   logic [2:0]  lost;
   logic [1:0]  bytes;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;
   assign s        = sextet_of(char_code);
   assign full_w   = {buf_ff, s};

   always_comb begin
      if (char_code == PAD_CODE) begin
         pads_in = (pads_ff == PAD_MAX) ? pads_ff : pads_ff + 3'd1;
      end else begin
         pads_in = 3'd0;
      end
   end

   // Final group: count pads and missing characters against three bytes.
   always_comb begin
      n        = {1'b0, pos_ff} + 3'd1;
      pads_eff = (pads_in < n) ? pads_in : n;
      lost     = pads_eff + (3'd4 - n);
      bytes    = (lost >= 3'd3) ? 2'd0 : 2'(3'd3 - lost);
   end

   always_comb begin
      case (pos_ff)
         2'd0:    shifted = {full_w[5:0], 18'd0};
         2'd1:    shifted = {full_w[11:0], 12'd0};
         2'd2:    shifted = {full_w[17:0], 6'd0};
         default: shifted = full_w;
      endcase
   end

   always_comb begin
      job.word      = final_char ? shifted : full_w;
      job.nbytes    = final_char ? bytes : 2'd3;
      job.final_grp = final_char;
      job.bad       = final_char && (pads_eff == n);
      push          = accept && (final_char || pos_ff == 2'd3);
   end

   always_comb begin
      buf_in = buf_ff;
      pos_in = pos_ff;
      if (final_char || pos_ff == 2'd3) begin
         buf_in = 18'd0;
         pos_in = 2'd0;
      end else begin
         buf_in = full_w[17:0];
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= 18'd0;
         pos_ff  <= 2'd0;
         pads_ff <= 3'd0;
      end else if (accept) begin
         buf_ff  <= buf_in;
         pos_ff  <= pos_in;
         pads_ff <= final_char ? 3'd0 : pads_in;
      end
   end

endmodule

// File: hw/rtl/b64d_queue.sv
// Short job queue between the front and the back.
module b64d_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  b64d_pkg::job_type          push_job,
   input  logic                       pop,
   output b64d_pkg::job_type          head_job,
   output b64d_pkg::queue_status_type status
);
   import b64d_pkg::*;

   job_type             slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: hw/rtl/b64d_back.sv
// Back end: holds one job and emits its bytes, or a lone end marker, one beat per cycle while out_ready is high.
module b64d_back (
   input  logic                       clock,
   input  logic                       reset,
   input  b64d_pkg::queue_status_type q_status,
   input  b64d_pkg::job_type          head_job,
   output logic                       pop,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [7:0]                 data_byte,
   output logic                       end_of_output,
   output logic                       no_byte,
   output logic                       bad_length
);
   import b64d_pkg::*;

   logic        busy_ff;
   job_type     job_ff;
   logic [1:0]  idx_ff, idx_in;
   logic [1:0]  beats_m1;
   logic        last_beat;

   assign beats_m1  = (job_ff.nbytes == 2'd0) ? 2'd0 : job_ff.nbytes - 2'd1;
   assign last_beat = (idx_ff == beats_m1);
   assign pop       = !q_status.empty && (!busy_ff || (out_ready && last_beat));
   assign idx_in    = idx_ff + 2'd1;

   always_comb begin
      out_valid     = busy_ff;
      no_byte       = (job_ff.nbytes == 2'd0);
      end_of_output = job_ff.final_grp && last_beat;
      bad_length    = job_ff.bad && no_byte;
      case (idx_ff)
         2'd0:    data_byte = job_ff.word[23:16];
         2'd1:    data_byte = job_ff.word[15:8];
         default: data_byte = job_ff.word[7:0];
      endcase
      if (no_byte) begin
         data_byte = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= 2'd0;
      end else if (busy_ff && out_ready) begin
         if (last_beat) begin
            busy_ff <= 1'b0;
            idx_ff  <= 2'd0;
         end else begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
   end

endmodule

// File: test/base64_stream_decoder_unit_test.sv
// Self-checking testbench for the streaming base64 decoder: directed and random strings.
module base64_stream_decoder_unit_test;
   import b64d_pkg::*;

   localparam int unsigned RESET_CYCLES    = 6;
   localparam int unsigned HOLD_OFF_CYCLES = 80;    // long enough to fill the job queue
   localparam int unsigned SETTLE_CYCLES   = 20;    // idle time after the last drain before the final check
   localparam int unsigned WATCHDOG_LIMIT  = 2000;  // cycles with no beat on either side

   // One response beat as the decoder should present it.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_output;
      logic       no_byte;
      logic       bad_length;
   } rsp_beat_type;

   // Predicts the decoded bytes of each accepted character and checks the
   // response beats against them in order.
   class decoded_byte_board;
      logic [17:0]  sextets;    // sextets of the group so far
      logic [1:0]   position;   // characters of the group so far
      logic [2:0]   pad_run;    // run of pad characters ending at the latest one
      rsp_beat_type expected_beats[$];
      int unsigned  mismatches;

      function new();
         sextets    = '0;
         position   = '0;
         pad_run    = '0;
         mismatches = 0;
      endfunction

      // Map one character to its six-bit value; anything outside the alphabet is zero.
      static function logic [5:0] char_value(logic [7:0] code);
         if (code >= 8'h41 && code <= 8'h5A) return 6'(code - 8'h41);         // A..Z
         if (code >= 8'h61 && code <= 8'h7A) return 6'(code - 8'h61 + 8'd26); // a..z
         if (code >= 8'h30 && code <= 8'h39) return 6'(code - 8'h30 + 8'd52); // 0..9
         if (code == PLUS_CODE) return 6'd62;
         if (code == SLASH_CODE) return 6'd63;
         return 6'd0;
      endfunction

      function void queue_beat(logic [7:0] data, logic last, logic empty, logic bad);
         rsp_beat_type beat;
         beat.data_byte     = data;
         beat.end_of_output = last;
         beat.no_byte       = empty;
         beat.bad_length    = bad;
         expected_beats.push_back(beat);
      endfunction

      function int unsigned pending();
         return expected_beats.size();
      endfunction

      // Note one accepted character and queue the beats it causes.
      function void note_char(logic [7:0] code, logic last);
         logic [23:0] group_word;
         logic [23:0] aligned;
         int unsigned chars_in_group;
         int unsigned pads_in_group;
         int unsigned lost;
         int unsigned byte_count;
         int unsigned shift_amount;
         logic        bad;
         group_word = {sextets, char_value(code)};
         if (code == PAD_CODE) begin
            if (pad_run < PAD_MAX) pad_run++;
         end else begin
            pad_run = '0;
         end
         if (!last) begin
            if (position == 2'd3) begin
               // a complete group that is not final: all three bytes, pads decode as zero
               queue_beat(group_word[23:16], 1'b0, 1'b0, 1'b0);
               queue_beat(group_word[15:8], 1'b0, 1'b0, 1'b0);
               queue_beat(group_word[7:0], 1'b0, 1'b0, 1'b0);
               sextets  = '0;
               position = '0;
            end else begin
               sextets  = group_word[17:0];
               position = position + 2'd1;
            end
            return;
         end
         // final group: only pads inside this group and missing characters cost bytes
         chars_in_group = int'(position) + 1;
         pads_in_group  = (pad_run < chars_in_group) ? pad_run : chars_in_group;
         lost           = pads_in_group + 4 - chars_in_group;
         byte_count     = (lost >= 3) ? 0 : 3 - lost;
         bad            = (pads_in_group == chars_in_group);
         shift_amount   = 6 * (3 - int'(position));
         aligned        = group_word << shift_amount;
         for (int unsigned k = 0; k < byte_count; k++) begin
            queue_beat(aligned[23 - 8 * k -: 8], k == byte_count - 1, 1'b0, 1'b0);
         end
         if (byte_count == 0) queue_beat(8'h00, 1'b1, 1'b1, bad);
         sextets  = '0;
         position = '0;
         pad_run  = '0;
      endfunction

      // Compare one accepted response beat with the oldest expectation.
      function void check_beat(rsp_beat_type got);
         rsp_beat_type want;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: data_byte %02h end_of_output %0b no_byte %0b bad_length %0b",
                   got.data_byte, got.end_of_output, got.no_byte, got.bad_length);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %02h, actual %02h", want.data_byte, got.data_byte);
            mismatches++;
         end
         if (got.end_of_output !== want.end_of_output) begin
            $error("end_of_output: expected %0b, actual %0b",
                   want.end_of_output, got.end_of_output);
            mismatches++;
         end
         if (got.no_byte !== want.no_byte) begin
            $error("no_byte: expected %0b, actual %0b", want.no_byte, got.no_byte);
            mismatches++;
         end
         if (got.bad_length !== want.bad_length) begin
            $error("bad_length: expected %0b, actual %0b", want.bad_length, got.bad_length);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   b64d_req_if req_ch ();
   b64d_rsp_if rsp_ch ();

   base64_stream_decoder_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   decoded_byte_board board = new();

   int unsigned send_idle_pct;    // chance per cycle that the sender holds back
   int unsigned recv_idle_pct;    // chance per cycle that the receiver stalls
   bit          hold_off_req;     // ask the receiver for one long stall
   int unsigned chars_sent;
   int unsigned quiet_cycles;

   always #2 clock = ~clock;

   // Watch both channels on the pre-edge values: note each accepted character
   // before checking any beat of the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            board.note_char(req_ch.char_code, req_ch.final_char);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_beat('{data_byte: rsp_ch.data_byte,
                               end_of_output: rsp_ch.end_of_output,
                               no_byte: rsp_ch.no_byte,
                               bad_length: rsp_ch.bad_length});
         end
      end
   end

   // Abort when neither side moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            // hold ready low so the job queue fills and the front stalls req
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one character and hold it until the decoder takes it.
   task automatic send_char(input logic [7:0] code, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.char_code  <= code;
      req_ch.final_char <= last;
      do @(posedge clock); while (!req_ch.ready);
      chars_sent++;
   endtask

   task automatic send_text(input string text, input bit terminate);
      for (int i = 0; i < text.len(); i++) begin
         send_char(text[i], terminate && (i == text.len() - 1));
      end
   endtask

   function automatic logic [7:0] random_alphabet_char();
      int unsigned v;
      v = $urandom_range(63);
      if (v < 26) return 8'(8'h41 + v);
      if (v < 52) return 8'(8'h61 + v - 26);
      if (v < 62) return 8'(8'h30 + v - 52);
      return (v == 62) ? PLUS_CODE : SLASH_CODE;
   endfunction

   // Build one string and send it with the final flag on its last character.
   // Most strings are well formed; the rest are noise, stray pads and long pad runs.
   task automatic send_random_string();
      logic [7:0]  chars[$];
      int unsigned kind;
      int unsigned groups;
      int unsigned len;
      int unsigned pick;
      kind = $urandom_range(99);
      if (kind < 75) begin
         groups = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(0, 3);
         repeat (4 * groups) chars.push_back(random_alphabet_char());
         case ($urandom_range(4))
            0: repeat (4) chars.push_back(random_alphabet_char());
            1: begin
               repeat (3) chars.push_back(random_alphabet_char());
               chars.push_back(PAD_CODE);
            end
            2: begin
               repeat (2) chars.push_back(random_alphabet_char());
               repeat (2) chars.push_back(PAD_CODE);
            end
            3: repeat (2) chars.push_back(random_alphabet_char());
            default: repeat (3) chars.push_back(random_alphabet_char());
         endcase
      end else if (kind < 90) begin
         len = $urandom_range(1, 12);
         repeat (len) begin
            pick = $urandom_range(99);
            if (pick < 40) chars.push_back(8'($urandom_range(255)));
            else if (pick < 70) chars.push_back(PAD_CODE);
            else chars.push_back(random_alphabet_char());
         end
      end else begin
         // long pad runs push the pad counter into saturation
         len = $urandom_range(0, 6);
         repeat (len) chars.push_back(random_alphabet_char());
         len = $urandom_range(1, 10);
         repeat (len) chars.push_back(PAD_CODE);
      end
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
   endtask

   task automatic feed_random(input int unsigned count);
      int unsigned start;
      start = chars_sent;
      while (chars_sent - start < count) send_random_string();
   endtask

   // Drop valid and pause until every predicted beat has arrived.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.char_code  = 8'h00;
      req_ch.final_char = 1'b0;
      send_idle_pct     = 12;
      recv_idle_pct     = 75;
      hold_off_req      = 1'b0;
      chars_sent        = 0;
      quiet_cycles      = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed strings: full group, two pads, all-pad final group,
      // single character, lone pad, the + and / symbols, out-of-alphabet codes
      // in a non-final group, and a pad run that starts before the final group
      send_text("TWFu", 1'b1);
      send_text("TQ==", 1'b1);
      send_text("====", 1'b1);
      send_char(8'h41, 1'b1);
      send_char(PAD_CODE, 1'b1);
      send_text("//++", 1'b0);
      send_text("z9", 1'b1);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(PAD_CODE, 1'b0);
      send_char(PAD_CODE, 1'b1);

      // slow receiver
      feed_random(115);
      wait_drained();

      // slow sender
      send_idle_pct = 75;
      recv_idle_pct = 12;
      feed_random(115);
      wait_drained();

      // no idling; start with a long receiver hold-off while the sender pushes on
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_req  = 1'b1;
      feed_random(40);
      feed_random(85);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         $error("%0d expected beats never arrived", board.pending());
         board.mismatches++;
      end
      if (board.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
